// ===== hdl/indexed_list_insert_erase_core_defines.svh =====
// Assertion macros shared by the indexed list core.
`ifndef INDEXED_LIST_INSERT_ERASE_CORE_DEFINES_SVH
`define INDEXED_LIST_INSERT_ERASE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ILIE_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("indexed list assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ILIE_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("indexed list assertion failed");

`endif

// ===== hdl/ilie_pkg.sv =====
// Types, codes and constants shared by the indexed list core.
package ilie_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int KIND_W    = 3;
    localparam int POS_W     = 7;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int LEN_W     = 7;
    // Slot index width that covers the largest supported capacity.
    localparam int MAX_IDX_W = 10;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND    = 3'd0,
        KIND_INSERT    = 3'd1,
        KIND_ERASE     = 3'd2,
        KIND_OVERWRITE = 3'd3,
        KIND_READ      = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        COP_NONE       = 3'd0,
        COP_WRITE      = 3'd1,
        COP_INSERT     = 3'd2,
        COP_ERASE      = 3'd3,
        COP_LANE_LOAD  = 3'd4,
        COP_LANE_SHIFT = 3'd5
    } t_cell_op;

    typedef struct packed {
        t_cell_op               op;
        logic [MAX_IDX_W-1:0]   idx;
    } t_cell_cmd;

endpackage

// ===== hdl/ilie_if.sv =====
// Valid/ready channel interfaces for list requests and list results.
interface ilie_in_if import ilie_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;

    modport source (output valid, kind, position, value, input ready);
    modport sink   (input valid, kind, position, value, output ready);
endinterface

interface ilie_out_if import ilie_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_value;
    logic [LEN_W-1:0]    length;

    modport source (output valid, status, read_value, length, input ready);
    modport sink   (input valid, status, read_value, length, output ready);
endinterface

// ===== hdl/ilie_cell.sv =====
// One list slot with its neighbor links and its stage of the read lane.
module ilie_cell import ilie_pkg::*; #(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  t_cell_cmd             i_cmd,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    input  logic [DATA_WIDTH-1:0] i_lane,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_lane
);

    localparam logic [MAX_IDX_W-1:0] MY_IDX = MAX_IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] r_lane;
    logic                  w_eq;
    logic                  w_gt;

    assign w_eq = (i_cmd.idx == MY_IDX);
    assign w_gt = (MY_IDX > i_cmd.idx);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            COP_WRITE: begin
                if (w_eq) begin
                    r_data <= i_value;
                end
            end
            COP_INSERT: begin
                if (w_gt) begin
                    r_data <= i_left;
                end else if (w_eq) begin
                    r_data <= i_value;
                end
            end
            COP_ERASE: begin
                if (w_gt || w_eq) begin
                    r_data <= i_right;
                end
            end
            COP_LANE_LOAD: begin
                r_lane <= r_data;
            end
            COP_LANE_SHIFT: begin
                r_lane <= i_lane;
            end
            default: begin
            end
        endcase
    end

    assign o_data = r_data;
    assign o_lane = r_lane;

endmodule

// ===== hdl/indexed_list_insert_erase_core.sv =====
// Top level of the indexed list: a row of slot cells with a small controller.
// Append, insert, erase and overwrite update the slots when taken; the result is registered
// and one such item can be taken every cycle while the result side keeps up.
// An in-range read at position p copies all slots into the read lane and shifts it p times
// toward cell 0, then registers the value of cell 0 as its result; no new item is taken
// while the lane shifts. Reset clears the entry count and the controller; slot contents
// stay undefined.
`include "indexed_list_insert_erase_core_defines.svh"

module indexed_list_insert_erase_core import ilie_pkg::*; #(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ilie_in_if.sink     i_in,
    ilie_out_if.source  o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_SHIFT = 2'b10
    } t_state;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [MAX_IDX_W-1:0]   r_shift, n_shift;
    logic                   r_out_valid, n_out_valid;
    t_status                r_status, n_status;
    logic [VALUE_W-1:0]     r_rdata, n_rdata;
    logic [LEN_W-1:0]       r_len, n_len;

    t_cell_cmd              w_cmd;
    logic [DATA_WIDTH-1:0]  w_wvalue;
    logic [VALUE_W-1:0]     w_rd;
    logic [CMP_W-1:0]       w_pos_ext;
    logic [CMP_W-1:0]       w_cnt_ext;
    logic                   w_full;
    logic                   w_in_acc;
    logic                   w_out_free;
    logic [DATA_WIDTH-1:0]  w_data [CAPACITY];
    logic [DATA_WIDTH-1:0]  w_lane [CAPACITY];

    // Fit the port word to the stored word width and back.
    assign w_wvalue = DATA_WIDTH'(i_in.value);
    assign w_rd     = VALUE_W'(w_lane[0]);

    assign w_pos_ext  = CMP_W'(i_in.position);
    assign w_cnt_ext  = CMP_W'(r_count);
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc   = i_in.valid && i_in.ready;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_shift     = r_shift;
        n_out_valid = r_out_valid && !o_out.ready;
        n_status    = r_status;
        n_rdata     = r_rdata;
        n_len       = r_len;
        w_cmd.op    = COP_NONE;
        w_cmd.idx   = MAX_IDX_W'(w_pos_ext);
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_DONE;
                    n_rdata     = '0;
                    case (t_kind'(i_in.kind))
                        KIND_APPEND: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_cmd.op  = COP_WRITE;
                                w_cmd.idx = MAX_IDX_W'(r_count);
                                n_count   = r_count + 1'b1;
                            end
                        end
                        KIND_INSERT: begin
                            if (w_pos_ext > w_cnt_ext) begin
                                n_status = ST_RANGE;
                            end else if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_cmd.op = COP_INSERT;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        KIND_ERASE: begin
                            if (w_pos_ext >= w_cnt_ext) begin
                                n_status = ST_RANGE;
                            end else begin
                                w_cmd.op = COP_ERASE;
                                n_count  = r_count - 1'b1;
                            end
                        end
                        KIND_OVERWRITE: begin
                            if (w_pos_ext < w_cnt_ext) begin
                                w_cmd.op = COP_WRITE;
                            end else begin
                                n_status = ST_RANGE;
                            end
                        end
                        KIND_READ: begin
                            if (w_pos_ext < w_cnt_ext) begin
                                // The result waits until the lane reaches cell 0.
                                w_cmd.op    = COP_LANE_LOAD;
                                n_out_valid = 1'b0;
                                n_shift     = MAX_IDX_W'(w_pos_ext);
                                n_state     = S_SHIFT;
                            end else begin
                                n_status = ST_RANGE;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_len = LEN_W'(n_count);
                end
            end
            S_SHIFT: begin
                if (r_shift == '0) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_status    = ST_DONE;
                        n_rdata     = w_rd;
                        n_len       = LEN_W'(r_count);
                        n_state     = S_IDLE;
                    end
                end else begin
                    w_cmd.op = COP_LANE_SHIFT;
                    n_shift  = r_shift - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_shift     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_shift     <= n_shift;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_rdata  <= n_rdata;
        r_len    <= n_len;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_status;
    assign o_out.read_value = r_rdata;
    assign o_out.length     = r_len;

    generate
        for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_left;
            logic [DATA_WIDTH-1:0] w_right;
            logic [DATA_WIDTH-1:0] w_lane_in;
            if (k == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_data[k-1];
            end
            if (k == CAPACITY - 1) begin : g_last
                assign w_right   = '0;
                assign w_lane_in = '0;
            end else begin : g_mid_r
                assign w_right   = w_data[k+1];
                assign w_lane_in = w_lane[k+1];
            end
            ilie_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .INDEX      (k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_cmd   (w_cmd),
                .i_value (w_wvalue),
                .i_left  (w_left),
                .i_right (w_right),
                .i_lane  (w_lane_in),
                .o_data  (w_data[k]),
                .o_lane  (w_lane[k])
            );
        end
    endgenerate

    `ILIE_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))
    `ILIE_ASSERT_IMP(a_busy_blocks, i_clk, i_rst_n, r_state == S_SHIFT, !i_in.ready)
    `ILIE_ASSERT_NXT(a_quick_result, i_clk, i_rst_n, w_in_acc && n_state == S_IDLE, r_out_valid)
    `ILIE_ASSERT_NXT(a_count_hold, i_clk, i_rst_n, !w_in_acc, $stable(r_count))

endmodule

// ===== sim/tb_indexed_list_insert_erase_core.sv =====
// Self-checking testbench for the indexed list core: directed and random list traffic.
`timescale 1ns / 100ps

module tb_indexed_list_insert_erase_core;
    import ilie_pkg::*;

    localparam int CAPACITY         = DEF_CAPACITY;
    localparam int DATA_WIDTH       = DEF_DATA_WIDTH;
    localparam int RESET_CYCLES     = 8;
    localparam int RANDOM_ITEMS     = 900;
    localparam int PRESSURE_EVERY   = 300;
    localparam int PRESSURE_AT      = 100;
    localparam int PRESSURE_CYCLES  = 300;
    localparam int END_DRAIN_CYCLES = 100;
    localparam int TIMEOUT_NS       = 5000000;

    localparam logic [KIND_W-1:0] KIND_SPARE_5 = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
    } t_list_req;

    typedef struct {
        t_status            status;
        logic [VALUE_W-1:0] read_value;
        logic [LEN_W-1:0]   length;
    } t_list_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic               drv_valid = 1'b0;
    logic [KIND_W-1:0]  drv_kind  = '0;
    logic [POS_W-1:0]   drv_pos   = '0;
    logic [VALUE_W-1:0] drv_value = '0;
    logic               mon_ready = 1'b0;

    ilie_in_if  in_if ();
    ilie_out_if out_if ();

    assign in_if.valid    = drv_valid;
    assign in_if.kind     = drv_kind;
    assign in_if.position = drv_pos;
    assign in_if.value    = drv_value;
    assign out_if.ready   = mon_ready;

    indexed_list_insert_erase_core #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    // Predicted list contents, updated at every accepted request.
    logic [DATA_WIDTH-1:0] list_slots [CAPACITY];
    int                    list_len = 0;

    t_list_req    pending_reqs [$];
    t_list_result expected_results [$];

    int gen_len      = 0;
    int random_items = 0;
    int fail_count   = 0;
    int results_seen = 0;
    int send_gap     = 0;
    int send_burst   = 0;
    int recv_stall   = 0;
    int recv_burst   = 0;

    function automatic t_list_result apply_list_op(input t_list_req req);
        t_list_result res;
        int           pos;
        res.status     = ST_DONE;
        res.read_value = '0;
        pos            = int'(req.position);
        case (req.kind)
            KIND_APPEND: begin
                if (list_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    list_slots[list_len] = req.value;
                    list_len++;
                end
            end
            KIND_INSERT: begin
                // The range check takes priority over the full check.
                if (pos > list_len) begin
                    res.status = ST_RANGE;
                end else if (list_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (int k = list_len; k > pos; k--) list_slots[k] = list_slots[k-1];
                    list_slots[pos] = req.value;
                    list_len++;
                end
            end
            KIND_ERASE: begin
                if (pos >= list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int k = pos; k + 1 < list_len; k++) list_slots[k] = list_slots[k+1];
                    list_len--;
                end
            end
            KIND_OVERWRITE: begin
                if (pos < list_len) list_slots[pos] = req.value;
                else res.status = ST_RANGE;
            end
            KIND_READ: begin
                if (pos < list_len) res.read_value = list_slots[pos];
                else res.status = ST_RANGE;
            end
            default: ;
        endcase
        res.length = list_len[LEN_W-1:0];
        return res;
    endfunction

    // Idle length between transfers: mostly short, a few long, with idle-free bursts.
    function automatic int pick_gap(inout int burst);
        int roll;
        roll = $urandom_range(0, 99);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if (roll < 4) begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return $urandom;
    endfunction

    // Queues one request and tracks the list length so later positions can be aimed.
    task automatic queue_op(input logic [KIND_W-1:0] kind, input int pos,
                            input logic [VALUE_W-1:0] value);
        t_list_req req;
        req.kind     = kind;
        req.position = pos[POS_W-1:0];
        req.value    = value;
        pending_reqs.push_back(req);
        case (kind)
            KIND_APPEND: if (gen_len < CAPACITY) gen_len++;
            KIND_INSERT: if (pos <= gen_len && gen_len < CAPACITY) gen_len++;
            KIND_ERASE:  if (pos < gen_len) gen_len--;
            default: ;
        endcase
    endtask

    task automatic queue_random_op(input int grow_pct, input int shrink_pct,
                                   output bit counted);
        int                 roll;
        int                 pick;
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        roll    = $urandom_range(0, 99);
        pick    = $urandom_range(0, 99);
        value   = pick_value();
        counted = 1'b1;
        if (roll < 2) begin
            // Unused kind codes leave the list unchanged and still get a done result.
            case (pick % 3)
                0:       kind = KIND_SPARE_5;
                1:       kind = KIND_SPARE_6;
                default: kind = KIND_SPARE_7;
            endcase
            queue_op(kind, $urandom_range(0, CAPACITY), value);
            counted = 1'b0;
        end else if (roll < 10) begin
            case (pick % 4)
                0: queue_op(KIND_INSERT, (gen_len < CAPACITY) ?
                            $urandom_range(gen_len + 1, CAPACITY) : CAPACITY, value);
                1: queue_op(KIND_ERASE, $urandom_range(gen_len, CAPACITY), value);
                2: queue_op(KIND_OVERWRITE, $urandom_range(gen_len, CAPACITY), value);
                default: queue_op(KIND_READ, $urandom_range(gen_len, CAPACITY), value);
            endcase
        end else if (pick < grow_pct) begin
            if (roll % 2 == 0) queue_op(KIND_APPEND, $urandom_range(0, CAPACITY), value);
            else queue_op(KIND_INSERT, $urandom_range(0, gen_len), value);
        end else if (pick < grow_pct + shrink_pct) begin
            queue_op(KIND_ERASE, (gen_len > 0) ? $urandom_range(0, gen_len - 1) : 0, value);
        end else begin
            kind = (roll % 2 == 0) ? KIND_OVERWRITE : KIND_READ;
            queue_op(kind, (gen_len > 0) ? $urandom_range(0, gen_len - 1) : 0, value);
        end
    endtask

    // Request driver: predicts each transfer, then offers the next pending request.
    always @(posedge i_clk) begin
        t_list_req req;
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && in_if.ready) begin
                req.kind     = drv_kind;
                req.position = drv_pos;
                req.value    = drv_value;
                expected_results.push_back(apply_list_op(req));
            end
            if (!drv_valid || in_if.ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    drv_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    req = pending_reqs.pop_front();
                    drv_kind  <= req.kind;
                    drv_pos   <= req.position;
                    drv_value <= req.value;
                    drv_valid <= 1'b1;
                    send_gap = pick_gap(send_burst);
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each transfer with the oldest prediction.
    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            mon_ready <= 1'b0;
        end else begin
            if (out_if.valid && mon_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result: status %0d read_value %h length %0d",
                             $time, out_if.status, out_if.read_value, out_if.length);
                end else begin
                    want = expected_results.pop_front();
                    if (out_if.status !== want.status || out_if.read_value !== want.read_value ||
                        out_if.length !== want.length) begin
                        fail_count++;
                        $display({"%0t: mismatch: expected status %0d read_value %h length %0d,",
                                  " actual status %0d read_value %h length %0d"},
                                 $time, want.status, want.read_value, want.length,
                                 out_if.status, out_if.read_value, out_if.length);
                    end
                end
                // Now and then hold off long enough for the block to back up its input.
                if (results_seen % PRESSURE_EVERY == PRESSURE_AT) recv_stall = PRESSURE_CYCLES;
                else recv_stall = pick_gap(recv_burst);
            end
            if (recv_stall != 0) begin
                recv_stall--;
                mon_ready <= 1'b0;
            end else begin
                mon_ready <= 1'b1;
            end
        end
    end

    initial begin
        bit counted;

        // Directed part, starting from the empty list.
        queue_op(KIND_READ, 0, '0);
        queue_op(KIND_ERASE, 0, '0);
        queue_op(KIND_OVERWRITE, 0, 32'h1111_2222);
        queue_op(KIND_INSERT, 1, 32'h3333_4444);
        queue_op(KIND_INSERT, 0, 32'hFFFF_FFFF);
        queue_op(KIND_APPEND, 0, 32'h0000_0000);
        queue_op(KIND_APPEND, 0, 32'hA5A5_A5A5);
        queue_op(KIND_INSERT, 3, 32'h1234_5678);
        queue_op(KIND_INSERT, 1, 32'h5A5A_5A5A);
        queue_op(KIND_READ, 0, '0);
        queue_op(KIND_READ, 4, '0);
        queue_op(KIND_OVERWRITE, 2, 32'hDEAD_BEEF);
        queue_op(KIND_READ, 2, '0);
        queue_op(KIND_ERASE, 0, '0);
        queue_op(KIND_ERASE, 3, '0);
        queue_op(KIND_READ, 3, '0);
        queue_op(KIND_READ, 64, '0);
        queue_op(KIND_ERASE, 64, '0);
        queue_op(KIND_OVERWRITE, 64, 32'hFFFF_FFFF);
        queue_op(KIND_INSERT, 64, 32'hFFFF_FFFF);
        queue_op(KIND_SPARE_5, 0, 32'hFFFF_FFFF);
        queue_op(KIND_SPARE_6, 64, 32'h0F0F_0F0F);
        queue_op(KIND_SPARE_7, 1, 32'hF0F0_F0F0);
        queue_op(KIND_READ, 1, '0);

        // Random part: each round fills the list, presses on the full list, mixes traffic, then drains it.
        while (random_items < RANDOM_ITEMS) begin
            while (gen_len < CAPACITY && random_items < RANDOM_ITEMS) begin
                queue_random_op(60, 12, counted);
                random_items += counted;
            end
            repeat (6) begin
                if ($urandom_range(0, 1) == 0) queue_op(KIND_APPEND, 0, pick_value());
                else queue_op(KIND_INSERT, $urandom_range(0, CAPACITY), pick_value());
                random_items++;
            end
            repeat (40) begin
                queue_random_op(35, 35, counted);
                random_items += counted;
            end
            while (gen_len > 0 && random_items < RANDOM_ITEMS) begin
                queue_random_op(12, 60, counted);
                random_items += counted;
            end
            repeat (6) begin
                queue_random_op(30, 30, counted);
                random_items += counted;
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || drv_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (END_DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout with %0d results still expected", $time, expected_results.size());
        $display("status: fail");
        $finish;
    end

endmodule
